/* hdl/gaussian_blur_5x5_unit_macros.svh */
// assertion macros shared by the gaussian blur rtl
`ifndef GAUSSIAN_BLUR_5X5_UNIT_MACROS_SVH
`define GAUSSIAN_BLUR_5X5_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GB5_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GB5_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/gb5_pkg.sv */
// package with constants and types of the 5x5 gaussian blur
`default_nettype none

package gb5_pkg;

  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned WIDTH_W     = 12;
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned KDIM        = 5;
  localparam int unsigned ROWS_FULL   = KDIM - 1;
  localparam int unsigned COL_START   = KDIM - 1;
  localparam int unsigned MIN_WIDTH   = KDIM;
  localparam int unsigned ROW_W       = 3;
  localparam int unsigned LINE_W      = PIX_W * (KDIM - 1);
  localparam int unsigned COLUMN_W    = PIX_W * KDIM;
  localparam int unsigned WIDTH_RESET = 640;

  // kernel weights by class
  localparam int unsigned K_W1  = 1;
  localparam int unsigned K_W4  = 4;
  localparam int unsigned K_W7  = 7;
  localparam int unsigned K_W16 = 16;
  localparam int unsigned K_W26 = 26;
  localparam int unsigned K_W41 = 41;

  // sum bound 273 * 255 fits 17 bits; divide by 273 via reciprocal
  localparam int unsigned SUM_W       = 17;
  localparam int unsigned RECIP       = 122911;
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned PROD_W      = 2 * SUM_W;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int unsigned PIX_MAX     = 255;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned OCC_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [KDIM-1:0][COLUMN_W-1:0] gb5_win_t;

  typedef struct packed {
    logic valid;
    logic last;
  } gb5_ctrl_t;

endpackage

`default_nettype wire

/* hdl/gb5_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module gb5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/gb5_filter.sv */
// three-stage weighted sum and divide by 273 over the 5x5 window
`default_nettype none

module gb5_filter
  import gb5_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gb5_ctrl_t        in_ctrl_i,
  input  gb5_win_t         win_i,
  output gb5_ctrl_t        out_ctrl_o,
  output logic [PIX_W-1:0] filtered_o
);

  function automatic logic [PIX_W-1:0] px(input gb5_win_t w, input int unsigned r,
                                         input int unsigned c);
    return w[c][PIX_W*(KDIM-1-r) +: PIX_W];
  endfunction

  localparam int unsigned G4_W = PIX_W + 3;
  localparam int unsigned G_W  = PIX_W + 2;

  gb5_ctrl_t          a_ctrl_q, b_ctrl_q, c_ctrl_q;
  logic [G_W-1:0]     g1_q, g7_q, g16_q, g26_q;
  logic [G4_W-1:0]    g4_q;
  logic [PIX_W-1:0]   g41_q;
  logic [SUM_W-1:0]   sum_d, sum_q;
  logic [PROD_W-1:0]  prod_q;
  logic [QUOT_W-1:0]  quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_ctrl_q <= '0;
      b_ctrl_q <= '0;
      c_ctrl_q <= '0;
    end else begin
      a_ctrl_q <= in_ctrl_i;
      b_ctrl_q <= a_ctrl_q;
      c_ctrl_q <= b_ctrl_q;
    end
  end

  // pixels grouped by equal weight
  always_ff @(posedge clk_i) begin
    g1_q  <= G_W'(px(win_i, 0, 0)) + G_W'(px(win_i, 0, 4))
           + G_W'(px(win_i, 4, 0)) + G_W'(px(win_i, 4, 4));
    g4_q  <= G4_W'(px(win_i, 0, 1)) + G4_W'(px(win_i, 0, 3))
           + G4_W'(px(win_i, 1, 0)) + G4_W'(px(win_i, 1, 4))
           + G4_W'(px(win_i, 3, 0)) + G4_W'(px(win_i, 3, 4))
           + G4_W'(px(win_i, 4, 1)) + G4_W'(px(win_i, 4, 3));
    g7_q  <= G_W'(px(win_i, 0, 2)) + G_W'(px(win_i, 2, 0))
           + G_W'(px(win_i, 2, 4)) + G_W'(px(win_i, 4, 2));
    g16_q <= G_W'(px(win_i, 1, 1)) + G_W'(px(win_i, 1, 3))
           + G_W'(px(win_i, 3, 1)) + G_W'(px(win_i, 3, 3));
    g26_q <= G_W'(px(win_i, 1, 2)) + G_W'(px(win_i, 2, 1))
           + G_W'(px(win_i, 2, 3)) + G_W'(px(win_i, 3, 2));
    g41_q <= px(win_i, 2, 2);
  end

  assign sum_d = SUM_W'(g1_q) * SUM_W'(K_W1) + SUM_W'(g4_q) * SUM_W'(K_W4)
               + SUM_W'(g7_q) * SUM_W'(K_W7) + SUM_W'(g16_q) * SUM_W'(K_W16)
               + SUM_W'(g26_q) * SUM_W'(K_W26) + SUM_W'(g41_q) * SUM_W'(K_W41);

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP);
  end

  assign quot       = prod_q[RECIP_SHIFT +: QUOT_W];
  assign filtered_o = (quot > QUOT_W'(PIX_MAX)) ? PIX_W'(PIX_MAX) : quot[PIX_W-1:0];
  assign out_ctrl_o = c_ctrl_q;

endmodule

`default_nettype wire

/* hdl/gaussian_blur_5x5_unit.sv */
// top level of the streaming 5x5 gaussian blur
//
// Pixels enter on the s_axis channel in raster order, one transfer per pixel;
// tuser set marks the first pixel of a frame and clears the row and column
// counters. Results leave on m_axis: the blurred pixel two rows up and two
// columns left of the newest one, tlast on the last result of a row. Border
// pixels (two rows and columns each side) give no result.
// Throughput is one pixel per cycle while s_axis_tready is high. A result is
// valid on m_axis after the line store read at the edge of its pixel transfer,
// window shift, three filter stages and the write into an 8-entry output queue.
// s_axis_tready drops only when 8 results are pending between the input and
// the m_axis side, so a stalled receiver stops the input after at most 8
// outstanding results; nothing is lost or repeated.
// The user writes the image width (cfg_wr_en_i / cfg_wr_data_i) only while the
// block is idle, unchecked by the block; below 5 acts as 5, above 2048 as 2048.
// Reset clears the counters, the window and the output queue and sets the
// width to 640. The line store has no reset and needs no clearing pass.
`default_nettype none

`include "gaussian_blur_5x5_unit_macros.svh"

module gaussian_blur_5x5_unit
  import gb5_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [WIDTH_W-1:0] cfg_wr_data_i,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [PIX_W-1:0]   s_axis_tdata,   // [7:0] pixel
  input  logic               s_axis_tuser,   // [0] frame_start
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [PIX_W-1:0]   m_axis_tdata,   // [7:0] filtered
  output logic               m_axis_tlast
);

  logic [WIDTH_W-1:0] width_q;
  logic [WIDTH_W-1:0] width_eff;
  logic [COL_W-1:0]   width_last;

  logic [COL_W-1:0] col_count_d, col_count_q;
  logic [ROW_W-1:0] row_count_d, row_count_q;
  logic [COL_W-1:0] col_base, col;
  logic [ROW_W-1:0] row_base;
  logic             last, produce, in_xfer, out_xfer;

  logic             s1_valid_q, s1_prod_q, s1_last_q, s1_clear_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PIX_W-1:0] s1_pix_q;

  logic [LINE_W-1:0]   ram_rdata, line, line_wdata;
  logic [COLUMN_W-1:0] column;
  logic                fwd_valid_q;
  logic [COL_W-1:0]    fwd_col_q;
  logic [LINE_W-1:0]   fwd_data_q;

  gb5_win_t  win_q;
  gb5_ctrl_t s2_ctrl_q, f_ctrl;
  logic [PIX_W-1:0] f_filtered;

  logic [PIX_W:0]     fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [OCC_W-1:0]   fifo_cnt_q, occ_q;

  // width register and clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WIDTH_W'(WIDTH_RESET);
    end else if (cfg_wr_en_i) begin
      width_q <= cfg_wr_data_i;
    end
  end

  always_comb begin
    if (width_q < WIDTH_W'(MIN_WIDTH)) begin
      width_eff = WIDTH_W'(MIN_WIDTH);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      width_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      width_eff = width_q;
    end
  end

  assign width_last = COL_W'(width_eff - WIDTH_W'(1));

  // position of the incoming pixel
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign col_base = s_axis_tuser ? '0 : col_count_q;
  assign row_base = s_axis_tuser ? '0 : row_count_q;
  assign col      = (col_base > width_last) ? width_last : col_base;
  assign last     = (col == width_last);
  assign produce  = (row_base == ROW_W'(ROWS_FULL)) && (col >= COL_W'(COL_START));

  always_comb begin
    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (in_xfer) begin
      if (last) begin
        col_count_d = '0;
        row_count_d = (row_base == ROW_W'(ROWS_FULL)) ? row_base : row_base + ROW_W'(1);
      end else begin
        col_count_d = col + COL_W'(1);
        row_count_d = row_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
      s1_valid_q  <= 1'b0;
      s1_prod_q   <= 1'b0;
      s1_last_q   <= 1'b0;
      s1_clear_q  <= 1'b0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
      s1_valid_q  <= in_xfer;
      s1_prod_q   <= in_xfer && produce;
      s1_last_q   <= last;
      s1_clear_q  <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_col_q <= col;
    s1_pix_q <= s_axis_tdata;
  end

  // four previous rows per column
  gb5_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (s1_valid_q),
    .waddr_i(s1_col_q),
    .wdata_i(line_wdata),
    .raddr_i(col),
    .rdata_o(ram_rdata)
  );

  // bypass for a write at the edge that issued the read
  assign line       = (fwd_valid_q && (fwd_col_q == s1_col_q)) ? fwd_data_q : ram_rdata;
  assign column     = {line, s1_pix_q};
  assign line_wdata = column[LINE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (s1_valid_q) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fwd_col_q  <= s1_col_q;
      fwd_data_q <= line_wdata;
    end
  end

  // window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      s2_ctrl_q <= '0;
    end else begin
      s2_ctrl_q.valid <= s1_valid_q && s1_prod_q;
      s2_ctrl_q.last  <= s1_last_q;
      if (s1_valid_q) begin
        if (s1_clear_q) begin
          win_q[KDIM-2:0] <= '0;
        end else begin
          win_q[KDIM-2:0] <= win_q[KDIM-1:1];
        end
        win_q[KDIM-1] <= column;
      end
    end
  end

  gb5_filter u_filter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ctrl_i (s2_ctrl_q),
    .win_i     (win_q),
    .out_ctrl_o(f_ctrl),
    .filtered_o(f_filtered)
  );

  // output queue with credit over all results in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      occ_q      <= '0;
    end else begin
      if (f_ctrl.valid) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + OCC_W'(f_ctrl.valid) - OCC_W'(out_xfer);
      occ_q      <= occ_q + OCC_W'(in_xfer && produce) - OCC_W'(out_xfer);
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ctrl.valid) begin
      fifo_q[wr_ptr_q] <= {f_ctrl.last, f_filtered};
    end
  end

  assign s_axis_tready = (occ_q < OCC_W'(FIFO_DEPTH));
  assign m_axis_tvalid = (fifo_cnt_q != '0);
  assign m_axis_tdata  = fifo_q[rd_ptr_q][PIX_W-1:0];
  assign m_axis_tlast  = fifo_q[rd_ptr_q][PIX_W];

  `GB5_ASSERT_IMPL(a_occ_bound, 1'b1, occ_q <= OCC_W'(FIFO_DEPTH), "credit count overflow")
  `GB5_ASSERT_IMPL(a_fifo_le_occ, 1'b1, fifo_cnt_q <= occ_q, "queue holds more than credited")
  `GB5_ASSERT_IMPL(a_fifo_room, f_ctrl.valid, fifo_cnt_q < OCC_W'(FIFO_DEPTH), "write to full queue")
  `GB5_ASSERT_NEXT(a_prod_enters, in_xfer && produce, s1_valid_q && s1_prod_q, "result lost at entry")
  `GB5_ASSERT_IMPL(a_row_sat, 1'b1, row_count_q <= ROW_W'(ROWS_FULL), "row count past saturation")

endmodule

`default_nettype wire
